>>> src/opi_pkg.sv
package opi_pkg;

  // Field widths
  localparam int TS_W  = 32;
  localparam int DT_W  = 24;
  localparam int VEL_W = 24;
  localparam int POS_W = 48;
  localparam int ANG_W = 16;
  localparam int CFG_W = 24;
  localparam int P_W   = 48;   // yaw_rate * dt

  // Step limit register
  localparam logic [CFG_W-1:0] MAX_STEP_RST = 24'd100000;
  localparam logic [CFG_W-1:0] MIN_STEP     = 24'd10000;

  // Input function codes
  localparam logic FUNC_CLEAR = 1'b1;

  // Job queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  // CORDIC
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CORDIC_STEPS_MAX = 24;
  localparam int STEP_W = $clog2(CORDIC_STEPS_MAX);
  localparam int CV_W   = 34;
  localparam logic signed [CV_W-1:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic signed [CV_W-1:0] QUARTER_TURN = 34'sh040000000;
  localparam logic signed [CV_W-1:0] HALF_TURN    = 34'sh080000000;

  // Shared multiplier
  localparam int MA_W   = 35;
  localparam int MB_W   = CV_W;
  localparam int PROD_W = 64;
  localparam int RS_W   = 57;
  localparam logic signed [RS_W-1:0] RND22 = 57'sd2097152;
  localparam int RSH    = 22;

  // Shared divider: floor division by 2^k * 15625
  // 2e6 = 2^7 * 15625, 31250 = 2^1 * 15625, 512e6 = 2^15 * 15625
  localparam int DIV_NW   = 62;
  localparam int DIV_UW   = 64;
  localparam int DIV_SH_W = 4;
  localparam int DIG_W    = 16;   // quotient digit per pass
  localparam int REM_W    = 14;
  localparam int DIV_VW   = REM_W + DIG_W;
  localparam int DIV_MW   = 31;
  localparam int DIV_PW   = 60;
  localparam int DIV_RSH  = 44;
  localparam logic [DIV_VW-1:0] DIV_D     = 30'd15625;
  localparam logic [DIV_MW-1:0] DIV_RECIP = 31'd1125899907;  // ceil(2^44 / 15625)
  localparam logic [DIV_SH_W-1:0] SH_TURN = 4'd7;
  localparam logic [DIV_SH_W-1:0] SH_HALF = 4'd1;
  localparam logic [DIV_SH_W-1:0] SH_DISP = 4'd15;
  localparam logic signed [DIV_NW-1:0] BIAS_TURN = 62'sd1000000;
  localparam logic signed [DIV_NW-1:0] BIAS_HALF = 62'sd15625;
  localparam logic signed [DIV_NW-1:0] BIAS_DISP = 62'sd256000000;

  typedef enum logic [1:0] {
    KIND_CLEAR,
    KIND_HOLD,
    KIND_MOVE
  } kind_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_P,
    ST_DF,
    ST_WF,
    ST_WH,
    ST_CR,
    ST_CN,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_M7,
    ST_WX,
    ST_WY,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                    func;
    logic [TS_W-1:0]         timestamp_us;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
  } sample_t;

  typedef struct packed {
    logic                    accepted;
    logic                    is_initialized;
    logic signed [POS_W-1:0] pose_x;
    logic signed [POS_W-1:0] pose_y;
    logic signed [ANG_W-1:0] heading;
  } pose_t;

  typedef struct packed {
    kind_t                   kind;
    logic                    init;
    logic [DT_W-1:0]         dt;
    logic signed [VEL_W-1:0] vel_x;
    logic signed [VEL_W-1:0] vel_y;
    logic signed [VEL_W-1:0] yaw_rate;
  } job_t;

  // atan(2^-i) in 2^-32 turn units
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

>>> src/opi_front.sv
module opi_front import opi_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  sample_t          sample,
  input  logic             q_full,
  output logic             q_push,
  output job_t             q_job
);

  logic [CFG_W-1:0] max_step;
  logic             init_flag;
  logic [TS_W-1:0]  last_time;
  logic [CFG_W-1:0] lim;
  logic [TS_W-1:0]  d;
  logic             step_ok;

  // take a word whenever the queue has room
  assign sample_stall = q_full;
  assign q_push       = sample_valid & ~q_full;

  // classify the word
  always_comb begin
    lim     = (max_step < MIN_STEP) ? MIN_STEP : max_step;
    d       = sample.timestamp_us - last_time;
    step_ok = (d != '0) && (d <= {{(TS_W-CFG_W){1'b0}}, lim});
    q_job.dt       = d[DT_W-1:0];
    q_job.vel_x    = sample.vel_x;
    q_job.vel_y    = sample.vel_y;
    q_job.yaw_rate = sample.yaw_rate;
    if (sample.func == FUNC_CLEAR) begin
      q_job.kind = KIND_CLEAR;
      q_job.init = 1'b0;
    end else if (!init_flag || !step_ok) begin
      q_job.kind = KIND_HOLD;
      q_job.init = 1'b1;
    end else begin
      q_job.kind = KIND_MOVE;
      q_job.init = 1'b1;
    end
  end

  // step limit, first-sample flag and last timestamp
  always_ff @(posedge clk) begin
    if (rst) begin
      max_step  <= MAX_STEP_RST;
      init_flag <= 1'b0;
      last_time <= '0;
    end else begin
      if (cfg_we) begin
        max_step <= cfg_data;
      end
      if (q_push) begin
        if (sample.func == FUNC_CLEAR) begin
          init_flag <= 1'b0;
          last_time <= '0;
        end else begin
          init_flag <= 1'b1;
          last_time <= sample.timestamp_us;
        end
      end
    end
  end

endmodule

>>> src/opi_queue.sv
module opi_queue import opi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("push into full job queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst) pop |-> head_valid)
    else $error("pop from empty job queue");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("job queue count did not follow push");

endmodule

>>> src/opi_div.sv
module opi_div import opi_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [DIV_NW-1:0] num,
  input  logic [DIV_SH_W-1:0]      pre_shift,
  output logic                     done,
  output logic signed [DIV_NW-1:0] quo
);

  logic signed [DIV_NW-1:0] shifted;
  logic [DIV_UW-1:0]        ureg;
  logic [DIV_UW-1:0]        qreg;
  logic [REM_W-1:0]         rem;
  logic [DIG_W-1:0]         qd;
  logic                     neg;
  logic                     phase;
  logic                     busy;
  logic [1:0]               cnt;
  logic [DIV_VW-1:0]        v;
  logic [DIV_PW-1:0]        vm;
  logic [DIV_VW-1:0]        rv;

  // power-of-two part of the divisor is a plain arithmetic shift
  assign shifted = num >>> pre_shift;

  // radix 2^16 long division by 15625: reciprocal estimate, then remainder
  always_comb begin
    v  = {rem, ureg[DIV_UW-1 -: DIG_W]};
    vm = {{(DIV_PW-DIV_VW){1'b0}}, v} * {{(DIV_PW-DIV_MW){1'b0}}, DIV_RECIP};
    rv = v - {{(DIV_VW-DIG_W){1'b0}}, qd} * DIV_D;
  end

  // floor for negative numerators: q = ~floor((-n-1)/d)
  assign quo = neg ? ~qreg[DIV_NW-1:0] : qreg[DIV_NW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 1'b0;
      cnt   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= '0;
        neg   <= shifted[DIV_NW-1];
        ureg  <= {{(DIV_UW-DIV_NW){1'b0}}, (shifted[DIV_NW-1] ? ~shifted : shifted)};
        qreg  <= '0;
        rem   <= '0;
      end else if (busy) begin
        if (!phase) begin
          qd    <= vm[DIV_RSH+DIG_W-1:DIV_RSH];
          phase <= 1'b1;
        end else begin
          rem   <= rv[REM_W-1:0];
          qreg  <= {qreg[DIV_UW-DIG_W-1:0], qd};
          ureg  <= {ureg[DIV_UW-DIG_W-1:0], {DIG_W{1'b0}}};
          phase <= 1'b0;
          cnt   <= cnt + 1'b1;
          if (cnt == 2'(DIV_UW/DIG_W-1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider started while busy");

endmodule

>>> src/opi_back.sv
module opi_back import opi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  q_valid,
  input  job_t  q_job,
  output logic  q_pop,
  output logic  pose_valid,
  input  logic  pose_stall,
  output pose_t pose
);

  state_t state, state_next;

  // job
  logic                    init_r;
  logic                    accepted_r;
  logic [DT_W-1:0]         dt_r;
  logic signed [VEL_W-1:0] vx_r;
  logic signed [VEL_W-1:0] vy_r;
  logic signed [VEL_W-1:0] wr_r;

  // pose
  logic signed [POS_W-1:0] pos_x;
  logic signed [POS_W-1:0] pos_y;
  logic signed [ANG_W-1:0] yaw;

  // datapath
  logic signed [P_W-1:0]    p_reg;
  logic [ANG_W-1:0]         yaw_turn;
  logic signed [CV_W-1:0]   cx;
  logic signed [CV_W-1:0]   cy;
  logic signed [CV_W-1:0]   cz;
  logic                     cneg;
  logic [STEP_W-1:0]        ci;
  logic signed [PROD_W-1:0] t1;
  logic signed [RS_W-1:0]   rs_x;
  logic signed [RS_W-1:0]   rs_y;
  logic signed [MA_W-1:0]   rx;
  logic signed [MA_W-1:0]   ry;

  // shared multiplier
  logic                     mul_ld;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [PROD_W-1:0] prod;

  // shared divider
  logic                     div_start;
  logic signed [DIV_NW-1:0] div_num;
  logic [DIV_SH_W-1:0]      div_shift;
  logic                     div_done;
  logic signed [DIV_NW-1:0] div_quo;

  logic [31:0]              mu;
  logic signed [CV_W-1:0]   z0;
  logic signed [CV_W-1:0]   atan_v;
  logic signed [MB_W-1:0]   dt_s;

  opi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .num       (div_num),
    .pre_shift (div_shift),
    .done      (div_done),
    .quo       (div_quo)
  );

  assign dt_s   = $signed({{(MB_W-DT_W){1'b0}}, dt_r});
  assign mu     = {yaw, {(32-ANG_W){1'b0}}} + div_quo[31:0];
  assign z0     = CV_W'($signed(mu));
  assign atan_v = $signed(CV_W'(atan_turn(ci)));

  assign pose_valid          = (state == ST_OUT);
  assign pose.accepted       = accepted_r;
  assign pose.is_initialized = init_r;
  assign pose.pose_x         = pos_x;
  assign pose.pose_y         = pos_y;
  assign pose.heading        = yaw;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer: next state, multiplier and divider operands
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    mul_ld     = 1'b0;
    ma         = '0;
    mb         = '0;
    div_start  = 1'b0;
    div_num    = '0;
    div_shift  = SH_TURN;
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = (q_job.kind == KIND_MOVE) ? ST_P : ST_OUT;
        end
      end
      ST_P: begin
        mul_ld     = 1'b1;
        ma         = MA_W'(wr_r);
        mb         = dt_s;
        state_next = ST_DF;
      end
      ST_DF: begin
        div_start  = 1'b1;
        div_num    = (DIV_NW'($signed(prod[P_W-1:0])) <<< 1) + BIAS_TURN;
        div_shift  = SH_TURN;
        state_next = ST_WF;
      end
      ST_WF: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = (DIV_NW'(p_reg) <<< 10) + BIAS_HALF;
          div_shift  = SH_HALF;
          state_next = ST_WH;
        end
      end
      ST_WH: begin
        if (div_done) begin
          state_next = ST_CR;
        end
      end
      ST_CR: begin
        if (ci == STEP_W'(CORDIC_STEPS-1)) begin
          state_next = ST_CN;
        end
      end
      ST_CN: begin
        state_next = ST_M1;
      end
      ST_M1: begin
        mul_ld     = 1'b1;
        ma         = MA_W'(vx_r);
        mb         = cx;
        state_next = ST_M2;
      end
      ST_M2: begin
        mul_ld     = 1'b1;
        ma         = MA_W'(vy_r);
        mb         = cy;
        state_next = ST_M3;
      end
      ST_M3: begin
        mul_ld     = 1'b1;
        ma         = MA_W'(vx_r);
        mb         = cy;
        state_next = ST_M4;
      end
      ST_M4: begin
        mul_ld     = 1'b1;
        ma         = MA_W'(vy_r);
        mb         = cx;
        state_next = ST_M5;
      end
      ST_M5: begin
        state_next = ST_M6;
      end
      ST_M6: begin
        mul_ld     = 1'b1;
        ma         = rx;
        mb         = dt_s;
        state_next = ST_M7;
      end
      ST_M7: begin
        mul_ld     = 1'b1;
        ma         = ry;
        mb         = dt_s;
        div_start  = 1'b1;
        div_num    = (DIV_NW'(prod) <<< 1) + BIAS_DISP;
        div_shift  = SH_DISP;
        state_next = ST_WX;
      end
      ST_WX: begin
        if (div_done) begin
          div_start  = 1'b1;
          div_num    = (DIV_NW'(prod) <<< 1) + BIAS_DISP;
          div_shift  = SH_DISP;
          state_next = ST_WY;
        end
      end
      ST_WY: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!pose_stall) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // multiplier product register
  always_ff @(posedge clk) begin
    if (mul_ld) begin
      prod <= PROD_W'(ma) * PROD_W'(mb);
    end
  end

  // pose accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x      <= '0;
      pos_y      <= '0;
      yaw        <= '0;
      init_r     <= 1'b0;
      accepted_r <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            init_r     <= q_job.init;
            accepted_r <= 1'b0;
            if (q_job.kind == KIND_CLEAR) begin
              pos_x <= '0;
              pos_y <= '0;
              yaw   <= '0;
            end
          end
        end
        ST_WX: begin
          if (div_done) begin
            pos_x <= pos_x + $signed(div_quo[POS_W-1:0]);
          end
        end
        ST_WY: begin
          if (div_done) begin
            pos_y      <= pos_y + $signed(div_quo[POS_W-1:0]);
            yaw        <= yaw + $signed(yaw_turn);
            accepted_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // working registers of one move
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (q_valid) begin
          dt_r <= q_job.dt;
          vx_r <= q_job.vel_x;
          vy_r <= q_job.vel_y;
          wr_r <= q_job.yaw_rate;
        end
      end
      ST_DF: begin
        p_reg <= $signed(prod[P_W-1:0]);
      end
      ST_WF: begin
        if (div_done) begin
          yaw_turn <= div_quo[ANG_W-1:0];
        end
      end
      ST_WH: begin
        // midpoint angle, folded into the right half plane
        if (div_done) begin
          cx <= CORDIC_GAIN;
          cy <= '0;
          ci <= '0;
          if (z0 > QUARTER_TURN) begin
            cz   <= z0 - HALF_TURN;
            cneg <= 1'b1;
          end else if (z0 < -QUARTER_TURN) begin
            cz   <= z0 + HALF_TURN;
            cneg <= 1'b1;
          end else begin
            cz   <= z0;
            cneg <= 1'b0;
          end
        end
      end
      ST_CR: begin
        // one CORDIC rotation per cycle
        if (!cz[CV_W-1]) begin
          cx <= cx - (cy >>> ci);
          cy <= cy + (cx >>> ci);
          cz <= cz - atan_v;
        end else begin
          cx <= cx + (cy >>> ci);
          cy <= cy - (cx >>> ci);
          cz <= cz + atan_v;
        end
        ci <= ci + 1'b1;
      end
      ST_CN: begin
        if (cneg) begin
          cx <= -cx;
          cy <= -cy;
        end
      end
      ST_M2: begin
        t1 <= prod;
      end
      ST_M3: begin
        rs_x <= RS_W'(t1) - RS_W'(prod);
      end
      ST_M4: begin
        t1 <= prod;
      end
      ST_M5: begin
        rs_y <= RS_W'(t1) + RS_W'(prod);
        rx   <= MA_W'((rs_x + RND22) >>> RSH);
      end
      ST_M6: begin
        ry <= MA_W'((rs_y + RND22) >>> RSH);
      end
      default: ;
    endcase
  end

endmodule

>>> src/planar_odometry_integrator_top.sv
// Planar odometry integrator.
// Sample channel: sample_valid / sample_stall with a sample_t word (func,
// timestamp, body velocities, yaw rate). A word is taken on a clock edge
// with valid high and stall low. Result channel: pose_valid / pose_stall
// with one pose_t word per sample word, in order.
// cfg_we / cfg_data write the largest accepted time step (microseconds).
// A clear, a first sample or a rejected step is popped from the queue and
// moves the back end from idle straight to its result state. An integrated
// step offers its result word after the multiplies, four passes of the
// divide-by-constant unit and the CORDIC rotations. The integrator works on
// one word at a time; a four-entry job queue lets sample words be taken
// while the integrator is busy.
// Reset clears the pose, the first-sample flag and the queue, and loads
// a step limit of 100000 us. A stalled result word holds its value, and
// the queue fills and stalls the sample side once four words wait.
module planar_odometry_integrator_top import opi_pkg::*; #(
  parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  input  logic             sample_valid,
  output logic             sample_stall,
  input  sample_t          sample,
  output logic             pose_valid,
  input  logic             pose_stall,
  output pose_t            pose
);

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t push_job;
  job_t head_job;

  opi_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  opi_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  opi_back #(
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_valid    (q_valid),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .pose_valid (pose_valid),
    .pose_stall (pose_stall),
    .pose       (pose)
  );

endmodule

>>> tb/planar_odometry_integrator_top_test.sv
`timescale 1ns / 100ps

module planar_odometry_integrator_top_test;
  import opi_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int HOLD_CYCLES    = 600;
  localparam int DRAIN_CYCLES   = 400;
  localparam int N_RANDOM       = 1800;

  // arctan(2^-i) in 2^-32 turn units, first sixteen rotations
  localparam logic [31:0] ARCTAN [16] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };
  localparam longint GAIN_Q30 = 652032874;

  typedef struct {
    logic                    func;
    logic [TS_W-1:0]         ts;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
    logic signed [VEL_W-1:0] wr;
    bit                      chk;
    bit                      e_init;
  } dir_row_t;

  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_data;
  logic             sample_valid;
  logic             sample_stall;
  sample_t          sample;
  logic             pose_valid;
  logic             pose_stall;
  pose_t            pose;

  planar_odometry_integrator_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .pose_valid   (pose_valid),
    .pose_stall   (pose_stall),
    .pose         (pose)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Predictor state
  logic [CFG_W-1:0] step_limit;
  logic             seen_first;
  logic [TS_W-1:0]  prev_ts;
  logic [POS_W-1:0] acc_x;
  logic [POS_W-1:0] acc_y;
  logic [ANG_W-1:0] acc_yaw;

  pose_t pose_q [$];
  int    errors;
  int    n_moves;
  int    n_rejects;
  int    n_clears;
  int    n_results;
  bit    quiet;
  bit    hold_req;
  bit    pin_next;
  pose_t pinned;
  int    idle_cnt;

  function automatic longint floor_div(longint a, longint d);
    longint q;
    q = a / d;
    if ((a % d) != 0 && a < 0) q = q - 1;
    return q;
  endfunction

  function automatic longint round_div(longint a, longint d);
    return floor_div(2 * a + d, 2 * d);
  endfunction

  // Rotation-mode CORDIC on Q2.30, angle in 2^-32 turns
  task automatic rotate(input longint z_in, output longint c, output longint s);
    longint x, y, t, z;
    bit neg;
    x = GAIN_Q30;
    y = 0;
    z = z_in;
    neg = 1'b0;
    if (z > 64'sh40000000) begin
      z = z - 64'sh80000000;
      neg = 1'b1;
    end else if (z < -64'sh40000000) begin
      z = z + 64'sh80000000;
      neg = 1'b1;
    end
    for (int i = 0; i < 16; i++) begin
      if (z >= 0) begin
        t = x - (y >>> i);
        y = y + (x >>> i);
        z = z - longint'(ARCTAN[i]);
      end else begin
        t = x + (y >>> i);
        y = y - (x >>> i);
        z = z + longint'(ARCTAN[i]);
      end
      x = t;
    end
    c = neg ? -x : x;
    s = neg ? -y : y;
  endtask

  // Integrate one sample word into the predicted pose
  task automatic integrate(input sample_t w, output pose_t r);
    logic [31:0] d, lim, mu;
    longint dt, vx, vy, p, turn, half, z, c, s, rx, ry, dx, dy;
    bit moved;
    moved = 1'b0;
    if (w.func == FUNC_CLEAR) begin
      seen_first = 1'b0;
      prev_ts = '0;
      acc_x = '0;
      acc_y = '0;
      acc_yaw = '0;
      n_clears++;
    end else if (!seen_first) begin
      seen_first = 1'b1;
      prev_ts = w.timestamp_us;
    end else begin
      d = w.timestamp_us - prev_ts;
      lim = (step_limit < MIN_STEP) ? 32'(MIN_STEP) : 32'(step_limit);
      prev_ts = w.timestamp_us;
      if (d >= 1 && d <= lim) begin
        dt = longint'(d);
        vx = longint'(w.vel_x);
        vy = longint'(w.vel_y);
        p = longint'(w.yaw_rate) * dt;
        turn = round_div(p, 1000000);
        half = round_div(p * 512, 15625);
        mu = {acc_yaw, 16'h0} + half[31:0];
        z = longint'(signed'(mu));
        rotate(z, c, s);
        rx = (vx * c - vy * s + (64'sd1 <<< 21)) >>> 22;
        ry = (vx * s + vy * c + (64'sd1 <<< 21)) >>> 22;
        dx = round_div(rx * dt, 256000000);
        dy = round_div(ry * dt, 256000000);
        acc_x = acc_x + dx[POS_W-1:0];
        acc_y = acc_y + dy[POS_W-1:0];
        acc_yaw = acc_yaw + turn[ANG_W-1:0];
        moved = 1'b1;
        n_moves++;
      end else begin
        n_rejects++;
      end
    end
    r.accepted = moved;
    r.is_initialized = seen_first;
    r.pose_x = acc_x;
    r.pose_y = acc_y;
    r.heading = acc_yaw;
  endtask

  // Sample words taken: predict and queue the expected pose
  always @(posedge clk) begin
    pose_t r;
    if (!rst && sample_valid && !sample_stall) begin
      integrate(sample, r);
      if (pin_next) begin
        r = pinned;
        pin_next = 1'b0;
      end
      pose_q.push_back(r);
    end
  end

  // Result words: compare against the oldest expected pose
  always @(posedge clk) begin
    pose_t e;
    if (!rst && pose_valid && !pose_stall) begin
      n_results++;
      if (pose_q.size() == 0) begin
        $display("%0t: unexpected pose word %h", $time, pose);
        errors++;
      end else begin
        e = pose_q.pop_front();
        if (pose.accepted !== e.accepted)
          $display("%0t: accepted exp %0d got %0d", $time, e.accepted, pose.accepted);
        if (pose.is_initialized !== e.is_initialized)
          $display("%0t: is_initialized exp %0d got %0d", $time, e.is_initialized,
                   pose.is_initialized);
        if (pose.pose_x !== e.pose_x)
          $display("%0t: pose_x exp %0d got %0d", $time, e.pose_x, pose.pose_x);
        if (pose.pose_y !== e.pose_y)
          $display("%0t: pose_y exp %0d got %0d", $time, e.pose_y, pose.pose_y);
        if (pose.heading !== e.heading)
          $display("%0t: heading exp %0d got %0d", $time, e.heading, pose.heading);
        if (pose !== e) errors++;
      end
    end
  end

  // Watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (pose_valid && !pose_stall)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= WATCHDOG_LIMIT) begin
        $display("%0t: timeout, %0d poses outstanding", $time, pose_q.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Result side stall: random bursts, one long hold-off on request
  initial begin
    int n;
    pose_stall = 1'b1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        pose_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 5);
        pose_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end else begin
        pose_stall <= 1'b0;
        n = $urandom_range(1, 12);
        repeat (n) @(negedge clk);
      end
    end
  end

  // Offer one sample word; called right after a falling edge
  task automatic send(input sample_t w);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 5);
      sample_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample <= w;
    @(posedge clk);
    while (!(sample_valid && !sample_stall)) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    while (pose_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_limit(input logic [CFG_W-1:0] v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    step_limit = v;
  endtask

  function automatic logic signed [VEL_W-1:0] rand_vel();
    case ($urandom_range(0, 3))
      0: return VEL_W'($urandom);
      1: return VEL_W'($signed($urandom_range(0, 4000)) - 2000);
      2: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
      default: return VEL_W'($signed($urandom_range(0, 400000)) - 200000);
    endcase
  endfunction

  // Random word, mostly valid steps off the last timestamp
  function automatic sample_t rand_word(logic [TS_W-1:0] last_ts, logic [CFG_W-1:0] lim_cfg);
    sample_t w;
    logic [31:0] lim;
    int k;
    lim = (lim_cfg < MIN_STEP) ? 32'(MIN_STEP) : 32'(lim_cfg);
    w.func = 1'b0;
    w.vel_x = rand_vel();
    w.vel_y = rand_vel();
    w.yaw_rate = rand_vel();
    k = $urandom_range(0, 99);
    if (k < 3) begin
      w.func = FUNC_CLEAR;
      w.timestamp_us = $urandom;
    end else if (k < 70) w.timestamp_us = last_ts + $urandom_range(1, lim);
    else if (k < 78) w.timestamp_us = last_ts + ($urandom_range(0, 1) ? lim : 32'd1);
    else if (k < 82) w.timestamp_us = last_ts + lim + 1;
    else if (k < 86) w.timestamp_us = last_ts;
    else if (k < 90) w.timestamp_us = last_ts - $urandom_range(1, 1000);
    else if (k < 94) w.timestamp_us = $urandom;
    else w.timestamp_us = last_ts + $urandom_range(1, 20000);
    return w;
  endfunction

  dir_row_t rows [16];

  initial begin
    sample_t w;
    logic [TS_W-1:0] last_ts;
    logic [CFG_W-1:0] limits [7];
    int per_phase;

    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    sample_valid = 1'b0;
    sample = '0;
    errors = 0;
    n_moves = 0;
    n_rejects = 0;
    n_clears = 0;
    n_results = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    pin_next = 1'b0;
    idle_cnt = 0;
    step_limit = MAX_STEP_RST;
    seen_first = 1'b0;
    prev_ts = '0;
    acc_x = '0;
    acc_y = '0;
    acc_yaw = '0;

    // Directed rows; checked rows all expect a zero pose, with is_initialized from the row
    rows[0]  = '{1'b0, 32'd1000,       24'sd0,       24'sd0,       24'sd0,       1, 1};
    rows[1]  = '{1'b0, 32'd1000,       24'sd5000,    24'sd5000,    24'sd5000,    1, 1};
    rows[2]  = '{1'b0, 32'd500,        24'sd5000,    24'sd5000,    24'sd5000,    1, 1};
    rows[3]  = '{1'b0, 32'd100501,     24'sh7FFFFF,  24'sh7FFFFF,  24'sh7FFFFF,  1, 1};
    rows[4]  = '{1'b0, 32'd200501,     24'sh7FFFFF,  24'sh800000,  24'sh7FFFFF,  0, 0};
    rows[5]  = '{1'b0, 32'd200502,     24'sh800000,  24'sh7FFFFF,  24'sh800000,  0, 0};
    rows[6]  = '{1'b0, 32'd250502,     24'sd0,       24'sd0,       24'sd0,       0, 0};
    rows[7]  = '{1'b0, 32'd300000,     24'sd65536,   24'sd0,       24'sd16384,   0, 0};
    rows[8]  = '{1'b0, 32'd399000,     24'sd0,       24'sd65536,   24'sh800000,  0, 0};
    rows[9]  = '{FUNC_CLEAR, 32'hFFFFFFFF, 24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1, 0};
    rows[10] = '{FUNC_CLEAR, 32'd0,    24'sd0,       24'sd0,       24'sd0,       1, 0};
    rows[11] = '{1'b0, 32'hFFFFFFF0,   24'sd1,       24'sd1,       24'sd1,       1, 1};
    rows[12] = '{1'b0, 32'h00000010,   24'sd1,       -24'sd1,      24'sd3000000, 0, 0};
    rows[13] = '{1'b0, 32'h000186B0,   24'sd100000,  24'sd100000,  24'sd6000000, 0, 0};
    rows[14] = '{1'b0, 32'h000186B0,   24'sd0,       24'sd0,       24'sd0,       0, 0};
    rows[15] = '{1'b0, 32'h80000000,   24'sd7,       24'sd7,       24'sd7,       0, 0};

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      w.func = rows[i].func;
      w.timestamp_us = rows[i].ts;
      w.vel_x = rows[i].vx;
      w.vel_y = rows[i].vy;
      w.yaw_rate = rows[i].wr;
      if (rows[i].chk) begin
        pinned = '0;
        pinned.is_initialized = rows[i].e_init;
        pin_next = 1'b1;
      end
      send(w);
      while (pin_next) @(negedge clk);
    end

    // Random phases over several step limits, extremes included
    limits = '{24'd10000, 24'd0, 24'hFFFFFF, 24'd9999, 24'd10000000, 24'd100000, 24'd0};
    limits[6] = CFG_W'($urandom_range(10000, 2000000));
    per_phase = N_RANDOM / 7;
    last_ts = prev_ts;
    for (int ph = 0; ph < 7; ph++) begin
      set_limit(limits[ph]);
      quiet = (ph == 6);
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < per_phase; n++) begin
        w = rand_word(last_ts, limits[ph]);
        last_ts = (w.func == FUNC_CLEAR) ? '0 : w.timestamp_us;
        send(w);
      end
    end

    wait_idle();
    $display("Covered %0d pose words: %0d integrated steps, %0d rejected steps, %0d clears,",
             n_results, n_moves, n_rejects, n_clears);
    $display("over seven step limits including 0, 9999, 10000 and the 24-bit maximum.");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatching pose words", errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
